// File: rtl/lru_write_back_block_cache_unit_macros.svh
// Assertion macros for the block cache unit.
`ifndef LRU_WRITE_BACK_BLOCK_CACHE_UNIT_MACROS_SVH
`define LRU_WRITE_BACK_BLOCK_CACHE_UNIT_MACROS_SVH

`ifndef SYNTH
`define LWBC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lwbc assertion failed");
`define LWBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lwbc assertion failed");
`else
`define LWBC_ASSERT_SAME(label, clk, rst, ante, cons)
`define LWBC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/lwbc_pkg.sv
// Package with the types and constants of the block cache unit.
`default_nettype none

package lwbc_pkg;

  localparam int WAYS       = 8;
  localparam int WAY_BITS   = $clog2(WAYS);
  localparam int BLOCK_BITS = 64;
  localparam int ADDR_BITS  = 16;
  localparam int CFG_BITS   = 4;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [ADDR_BITS-1:0]  block_address;
    logic [BLOCK_BITS-1:0] write_data;
    logic [BLOCK_BITS-1:0] memory_data;
    logic                  last_of_request;
  } req_word_t;

  typedef struct packed {
    logic                  hit;
    logic [BLOCK_BITS-1:0] read_data;
    logic                  writeback;
    logic [ADDR_BITS-1:0]  writeback_address;
    logic [BLOCK_BITS-1:0] writeback_data;
    logic                  run_last;
    logic                  request_done;
  } rsp_word_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic pick;
    logic commit;
    logic bypass;
    logic flush;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] new_cmd;
    logic       bypass_mode;
    logic       scan_done;
    logic       out_free;
    logic       flush_last;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/lwbc_ctrl.sv
// Controller state machine that sequences lookups, updates and flushes.
`default_nettype none

module lwbc_ctrl
  import lwbc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    req_valid,
  output logic         req_stall,
  output ctrl_t        cmd_bus,
  input  wire status_t status
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_PICK   = 6'b000100,
    S_COMMIT = 6'b001000,
    S_BYPASS = 6'b010000,
    S_FLUSH  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_bus    = '0;
    req_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd_bus.load = 1'b1;
          case (status.new_cmd)
            CMD_READ, CMD_WRITE: state_next = status.bypass_mode ? S_BYPASS : S_SCAN;
            CMD_FLUSH: state_next = S_FLUSH;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd_bus.scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd_bus.pick = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (status.out_free) begin
          cmd_bus.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BYPASS: begin
        if (status.out_free) begin
          cmd_bus.bypass = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (status.out_free) begin
          cmd_bus.flush = 1'b1;
          if (status.flush_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/lwbc_datapath.sv
// Datapath with the entry store, recency ranks, way search and output register.
`default_nettype none

module lwbc_datapath
  import lwbc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctrl_t               cmd_bus,
  output status_t                  status,
  input  wire req_word_t           req,
  input  wire logic                cfg_we,
  input  wire logic [CFG_BITS-1:0] cfg_wdata,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output rsp_word_t                rsp
);

  logic [ADDR_BITS-1:0]  entry_tag   [WAYS];
  logic [BLOCK_BITS-1:0] entry_data  [WAYS];
  logic [WAYS-1:0]       entry_valid;
  logic [WAYS-1:0]       entry_dirty;
  logic [WAY_BITS-1:0]   recency_rank [WAYS];

  logic [CFG_BITS-1:0] ways_in_use;
  logic [CFG_BITS-1:0] nways;
  req_word_t           item;

  logic [WAY_BITS-1:0] way;
  logic                found;
  logic [WAY_BITS-1:0] hit_way;
  logic                empty_found;
  logic [WAY_BITS-1:0] empty_way;
  logic [WAY_BITS-1:0] lru_way;
  logic [WAY_BITS-1:0] best_rank;
  logic                victim;

  logic                match;
  logic                is_write;
  logic [WAY_BITS-1:0] pick_way;
  logic                flush_dirty;
  rsp_word_t           rsp_next;

  assign nways    = (ways_in_use > CFG_BITS'(WAYS)) ? CFG_BITS'(WAYS) : ways_in_use;
  assign match    = entry_valid[way] && (entry_tag[way] == item.block_address);
  assign is_write = (item.cmd == CMD_WRITE);
  assign pick_way = found ? hit_way : (empty_found ? empty_way : lru_way);
  assign flush_dirty = entry_valid[way] && entry_dirty[way];

  assign status.new_cmd     = req.cmd;
  assign status.bypass_mode = (nways == '0);
  assign status.scan_done   = match ||
                              ({{(CFG_BITS-WAY_BITS){1'b0}}, way} == nways - 1'b1);
  assign status.out_free    = !rsp_valid || !rsp_stall;
  assign status.flush_last  = (way == WAY_BITS'(WAYS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= CFG_BITS'(WAYS);
    end else if (cfg_we) begin
      ways_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.load) begin
      item        <= req;
      way         <= '0;
      found       <= 1'b0;
      empty_found <= 1'b0;
      lru_way     <= '0;
      best_rank   <= '0;
    end
    if (cmd_bus.scan) begin
      if (match) begin
        found   <= 1'b1;
        hit_way <= way;
      end else begin
        way <= way + 1'b1;
      end
      if (!entry_valid[way] && !empty_found) begin
        empty_found <= 1'b1;
        empty_way   <= way;
      end
      if (recency_rank[way] > best_rank) begin
        best_rank <= recency_rank[way];
        lru_way   <= way;
      end
    end
    if (cmd_bus.pick) begin
      way    <= pick_way;
      victim <= !found && !empty_found && entry_dirty[pick_way];
    end
    if (cmd_bus.flush) begin
      way <= way + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.commit) begin
      if (!found || is_write) begin
        entry_data[way] <= is_write ? item.write_data : item.memory_data;
      end
      if (!found) begin
        entry_tag[way] <= item.block_address;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_dirty <= '0;
      for (int i = 0; i < WAYS; i++) begin
        recency_rank[i] <= WAY_BITS'(i);
      end
    end else begin
      if (cmd_bus.commit) begin
        entry_valid[way] <= 1'b1;
        if (!found || is_write) begin
          entry_dirty[way] <= is_write;
        end
        for (int i = 0; i < WAYS; i++) begin
          if (recency_rank[i] < recency_rank[way]) begin
            recency_rank[i] <= recency_rank[i] + 1'b1;
          end
        end
        recency_rank[way] <= '0;
      end
      if (cmd_bus.flush) begin
        entry_dirty[way] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd_bus.commit || cmd_bus.bypass || cmd_bus.flush) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    rsp_next = rsp;
    if (cmd_bus.commit) begin
      rsp_next = '0;
      rsp_next.hit          = found;
      rsp_next.run_last     = 1'b1;
      rsp_next.request_done = item.last_of_request;
      if (!is_write) begin
        rsp_next.read_data = found ? entry_data[way] : item.memory_data;
      end
      if (victim) begin
        rsp_next.writeback         = 1'b1;
        rsp_next.writeback_address = entry_tag[way];
        rsp_next.writeback_data    = entry_data[way];
      end
    end else if (cmd_bus.bypass) begin
      rsp_next = '0;
      rsp_next.run_last     = 1'b1;
      rsp_next.request_done = item.last_of_request;
      if (is_write) begin
        rsp_next.writeback         = 1'b1;
        rsp_next.writeback_address = item.block_address;
        rsp_next.writeback_data    = item.write_data;
      end else begin
        rsp_next.read_data = item.memory_data;
      end
    end else if (cmd_bus.flush) begin
      rsp_next = '0;
      rsp_next.run_last     = status.flush_last;
      rsp_next.request_done = status.flush_last && item.last_of_request;
      if (flush_dirty) begin
        rsp_next.writeback         = 1'b1;
        rsp_next.writeback_address = entry_tag[way];
        rsp_next.writeback_data    = entry_data[way];
      end
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule

`default_nettype wire

// File: rtl/lru_write_back_block_cache_unit.sv
// A read or write passes an accept state, a search of one to eight ways (one way per cycle),
// a pick state and a commit state; the result word then appears in the output register.
// A bypassed access goes from acceptance to a bypass state that registers its word. A flush
// gives eight words, one per cycle while the output is not stalled. One access is in progress
// at a time. Synchronous reset empties and cleans every entry, sets recency to way order with
// way 0 newest, and sets the way count to eight.
`default_nettype none
`include "lru_write_back_block_cache_unit_macros.svh"

module lru_write_back_block_cache_unit
  import lwbc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire req_word_t           req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output rsp_word_t                rsp,
  input  wire logic                cfg_we,
  input  wire logic [CFG_BITS-1:0] cfg_wdata
);

  ctrl_t   cmd_bus;
  status_t status;

  lwbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd_bus   (cmd_bus),
    .status    (status)
  );

  lwbc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd_bus   (cmd_bus),
    .status    (status),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `LWBC_ASSERT_SAME(a_one_command, clk, rst, 1'b1, $onehot0(cmd_bus))
  `LWBC_ASSERT_SAME(a_emit_when_free, clk, rst,
    cmd_bus.commit || cmd_bus.bypass || cmd_bus.flush, status.out_free)
  `LWBC_ASSERT_NEXT(a_no_word_after_accept, clk, rst,
    req_valid && !req_stall, !$rose(rsp_valid))

endmodule

`default_nettype wire
